// File: src/som_pkg.sv
// Shared types and constants for the self-organizing map training block.
`timescale 1ns / 1ps
package som_pkg;
    localparam int ELEM_W = 16;
    localparam int DIST_W = 36;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd4;

    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [3:0]        neuron_row;
        logic [3:0]        neuron_col;
        logic [3:0]        element_index;
        logic signed [15:0] element_value;
        logic              last;
    } som_in_t;

    typedef struct packed {
        logic [3:0]  winner_row;
        logic [3:0]  winner_col;
        logic [35:0] winner_distance;
    } som_out_t;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_SREAD  = 11'b00000000010,
        ST_SDIFF  = 11'b00000000100,
        ST_SACC   = 11'b00000001000,
        ST_SCMP   = 11'b00000010000,
        ST_WIN    = 11'b00000100000,
        ST_UREAD  = 11'b00001000000,
        ST_UDIFF  = 11'b00010000000,
        ST_UMUL   = 11'b00100000000,
        ST_UWRITE = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } som_state_t;
endpackage

// File: src/som_if.sv
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
interface som_in_if
    import som_pkg::*;
;
    logic    valid;
    logic    ready;
    som_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface som_out_if
    import som_pkg::*;
;
    logic     valid;
    logic     ready;
    som_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/som_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module som_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: src/som_best_match_and_update.sv
// Top level: best-matching-unit search and neighborhood weight update.
// Weight loads and non-final sample items are taken one per cycle, back to back, while idle.
// A final sample item starts the search and then the update, sharing one RAM port and one
// multiplier: SREAD, SDIFF and SACC per element and SCMP per neuron in the search, and UREAD,
// UDIFF, UMUL and UWRITE per element in the update; then OUT loads the result register.
// The result waits there and blocks input; async rst_n resets control and config registers.
`timescale 1ns / 1ps
module som_best_match_and_update
    import som_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    parameter int MAX_DIM = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    som_in_if.sink                in_ch,
    som_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS * MAX_DIM;
    localparam int AW = $clog2(DEPTH);
    localparam int ACC_W = 33 + KW;

    logic [4:0]  grid_rows_reg, grid_cols_reg, vlen_reg;
    logic [15:0] rate_reg;
    logic [3:0]  radius_reg;

    som_state_t state_reg, state_next;
    logic [RW-1:0] r_reg, br_reg, rhi_reg;
    logic [CW-1:0] c_reg, bc_reg, clo_reg, chi_reg;
    logic [KW-1:0] k_reg;
    logic [ACC_W-1:0] acc_reg, best_reg;
    logic found_reg;
    logic signed [15:0] samp [MAX_DIM];
    som_out_t out_reg;
    logic out_valid_reg;
    logic signed [16:0] diff_reg;
    logic signed [33:0] prod_reg;

    logic [RW-1:0] rows_m1;
    logic [CW-1:0] cols_m1;
    logic [KW-1:0] len_m1;

    always_comb
    begin
        if (grid_rows_reg == 5'd0) rows_m1 = '0;
        else if (32'(grid_rows_reg) > MAX_ROWS) rows_m1 = RW'(MAX_ROWS - 1);
        else rows_m1 = RW'(grid_rows_reg - 5'd1);
        if (grid_cols_reg == 5'd0) cols_m1 = '0;
        else if (32'(grid_cols_reg) > MAX_COLS) cols_m1 = CW'(MAX_COLS - 1);
        else cols_m1 = CW'(grid_cols_reg - 5'd1);
        if (vlen_reg == 5'd0) len_m1 = '0;
        else if (32'(vlen_reg) > MAX_DIM) len_m1 = KW'(MAX_DIM - 1);
        else len_m1 = KW'(vlen_reg - 5'd1);
    end

    logic in_fire;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_fire = in_ch.valid && in_ch.ready;

    // RAM port
    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0] ram_wdata, ram_rdata;

    som_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_wram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic load_ok;
    assign load_ok = (32'(in_ch.data.neuron_row) < MAX_ROWS)
                  && (32'(in_ch.data.neuron_col) < MAX_COLS)
                  && (32'(in_ch.data.element_index) < MAX_DIM);

    // Shared unit: the registered difference times itself or times the rate.
    logic signed [15:0] s_k;
    logic signed [16:0] diff_now;
    logic signed [16:0] mul_b;
    logic signed [33:0] prod;
    assign s_k = samp[k_reg];
    assign diff_now = 17'(s_k) - 17'($signed(ram_rdata));
    assign mul_b = (state_reg == ST_UMUL) ? $signed({1'b0, rate_reg}) : diff_reg;
    assign prod = diff_reg * mul_b;

    // Round to nearest with halves toward +inf, then add to the old weight.
    logic signed [34:0] rounded;
    logic signed [18:0] delta;
    logic signed [19:0] neww;
    logic [15:0] neww_sat;
    assign rounded = 35'(prod_reg) + 35'sd32768;
    assign delta = 19'(rounded >>> 16);
    assign neww = 20'($signed(ram_rdata)) + 20'(delta);
    always_comb
    begin
        if (neww > 20'sd32767) neww_sat = 16'h7fff;
        else if (neww < -20'sd32768) neww_sat = 16'h8000;
        else neww_sat = 16'(neww);
    end

    logic [7:0] rlo_w, rhi_w, clo_w, chi_w;
    always_comb
    begin
        rlo_w = (8'(br_reg) >= 8'(radius_reg)) ? 8'(br_reg) - 8'(radius_reg) : 8'd0;
        clo_w = (8'(bc_reg) >= 8'(radius_reg)) ? 8'(bc_reg) - 8'(radius_reg) : 8'd0;
        rhi_w = 8'(br_reg) + 8'(radius_reg);
        chi_w = 8'(bc_reg) + 8'(radius_reg);
        if (rhi_w > 8'(rows_m1)) rhi_w = 8'(rows_m1);
        if (chi_w > 8'(cols_m1)) chi_w = 8'(cols_m1);
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_wdata = neww_sat;
        ram_addr = AW'((32'(r_reg) * MAX_COLS + 32'(c_reg)) * MAX_DIM + 32'(k_reg));
        if (state_reg == ST_IDLE)
        begin
            ram_addr = AW'((32'(in_ch.data.neuron_row) * MAX_COLS
                          + 32'(in_ch.data.neuron_col)) * MAX_DIM
                          + 32'(in_ch.data.element_index));
            ram_wdata = in_ch.data.element_value;
            ram_we = in_fire && (in_ch.data.mode == MODE_WEIGHT) && load_ok;
        end
        else if (state_reg == ST_UWRITE)
        begin
            ram_we = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire && in_ch.data.mode == MODE_SAMPLE && in_ch.data.last)
                    state_next = ST_SREAD;
            ST_SREAD: state_next = ST_SDIFF;
            ST_SDIFF: state_next = ST_SACC;
            ST_SACC:
                if (k_reg == len_m1) state_next = ST_SCMP;
                else state_next = ST_SREAD;
            ST_SCMP:
                if (r_reg == rows_m1 && c_reg == cols_m1) state_next = ST_WIN;
                else state_next = ST_SREAD;
            ST_WIN: state_next = ST_UREAD;
            ST_UREAD: state_next = ST_UDIFF;
            ST_UDIFF: state_next = ST_UMUL;
            ST_UMUL: state_next = ST_UWRITE;
            ST_UWRITE:
                if (k_reg == len_m1 && r_reg == rhi_reg && c_reg == chi_reg)
                    state_next = ST_OUT;
                else state_next = ST_UREAD;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            grid_rows_reg <= 5'd16;
            grid_cols_reg <= 5'd16;
            vlen_reg <= 5'd16;
            rate_reg <= 16'd52429;
            radius_reg <= 4'd1;
            r_reg <= '0;
            c_reg <= '0;
            k_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_ROWS: grid_rows_reg <= cfg_data[4:0];
                    CFG_GRID_COLS: grid_cols_reg <= cfg_data[4:0];
                    CFG_VECTOR_LENGTH: vlen_reg <= cfg_data[4:0];
                    CFG_LEARN_RATE: rate_reg <= cfg_data;
                    CFG_RADIUS: radius_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT) out_valid_reg <= 1'b1;
            else if (out_ch.ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    r_reg <= '0;
                    c_reg <= '0;
                    k_reg <= '0;
                    found_reg <= 1'b0;
                end
                ST_SACC:
                begin
                    if (k_reg != len_m1) k_reg <= k_reg + KW'(1);
                end
                ST_SCMP:
                begin
                    k_reg <= '0;
                    found_reg <= 1'b1;
                    if (c_reg == cols_m1)
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + RW'(1);
                    end
                    else c_reg <= c_reg + CW'(1);
                end
                ST_WIN:
                begin
                    r_reg <= RW'(rlo_w);
                    c_reg <= CW'(clo_w);
                    k_reg <= '0;
                end
                ST_UWRITE:
                begin
                    if (k_reg == len_m1)
                    begin
                        k_reg <= '0;
                        if (c_reg == chi_reg)
                        begin
                            c_reg <= clo_reg;
                            r_reg <= r_reg + RW'(1);
                        end
                        else c_reg <= c_reg + CW'(1);
                    end
                    else k_reg <= k_reg + KW'(1);
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.data.mode == MODE_SAMPLE
            && 32'(in_ch.data.element_index) < MAX_DIM)
        begin
            samp[KW'(in_ch.data.element_index)] <= in_ch.data.element_value;
        end
        if (state_reg == ST_SDIFF || state_reg == ST_UDIFF) diff_reg <= diff_now;
        if (state_reg == ST_SACC)
            acc_reg <= ((k_reg == '0) ? '0 : acc_reg) + ACC_W'($unsigned(prod));
        if (state_reg == ST_UMUL) prod_reg <= prod;
        // The first neuron always wins; later ones only with a strictly smaller distance.
        if (state_reg == ST_SCMP && (!found_reg || acc_reg < best_reg))
        begin
            best_reg <= acc_reg;
            br_reg <= r_reg;
            bc_reg <= c_reg;
        end
        if (state_reg == ST_WIN)
        begin
            clo_reg <= CW'(clo_w);
            rhi_reg <= RW'(rhi_w);
            chi_reg <= CW'(chi_w);
        end
        if (state_reg == ST_OUT)
        begin
            out_reg.winner_row <= 4'(br_reg);
            out_reg.winner_col <= 4'(bc_reg);
            out_reg.winner_distance <= (best_reg > ACC_W'(36'hfffffffff))
                ? 36'hfffffffff : 36'(best_reg);
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;
endmodule

// File: src/som_checker.sv
// Port-level checks on the training block, bound to the top level.
`timescale 1ns / 1ps
module som_checker
    import som_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input som_in_t  in_data,
    input logic     out_valid,
    input logic     out_ready,
    input som_out_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.mode == MODE_SAMPLE && in_data.last |=> !in_ready)
        else $error("ready after final sample item");
    a_no_take_with_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_weight_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.mode == MODE_WEIGHT |=> !out_valid)
        else $error("result after weight load");
endmodule

bind som_best_match_and_update som_checker u_som_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: tb/som_best_match_and_update_tb.sv
// Self-checking testbench for the SOM best-match search and neighborhood update block.
`timescale 1ns / 1ps
module som_best_match_and_update_tb;
    import som_pkg::*;

    localparam int GRID = 16;
    localparam int DIM = 16;
    localparam int TARGET_ITEMS = 1050;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    som_in_if  in_ch ();
    som_out_if out_ch ();

    som_best_match_and_update u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Register copies as seen by the predictor.
    logic [4:0]  rows_reg = 5'd16;
    logic [4:0]  cols_reg = 5'd16;
    logic [4:0]  len_reg = 5'd16;
    logic [15:0] rate_reg = 16'd52429;
    logic [3:0]  radius_reg = 4'd1;

    logic signed [15:0] weight_mem [GRID*GRID*DIM];
    logic signed [15:0] sample_mem [DIM];

    // Generator-side bookkeeping of which entries hold data.
    bit weight_loaded [GRID*GRID*DIM];
    bit sample_loaded [DIM];

    som_in_t  pending_items [$];
    som_out_t expected_wins [$];

    int errors = 0;
    int items_made = 0;
    int items_in = 0;
    int wins_out = 0;
    int finals_made = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic int clip(input int v);
        if (v < 1) return 1;
        if (v > 16) return 16;
        return v;
    endfunction

    function automatic int addr(input int r, input int c, input int k);
        return (r * GRID + c) * DIM + k;
    endfunction

    function automatic logic signed [15:0] nudge(input logic signed [15:0] w,
                                                 input logic signed [15:0] s);
        longint p;
        longint step;
        longint n;
        p = longint'(rate_reg) * (longint'(s) - longint'(w));
        step = (p + 32768) >>> 16;
        n = longint'(w) + step;
        if (n > 32767) n = 32767;
        if (n < -32768) n = -32768;
        return n[15:0];
    endfunction

    // Applies one accepted item to the shadow state and queues any win report.
    function automatic void train_step(input som_in_t it);
        int rows;
        int cols;
        int len;
        int br;
        int bc;
        int rlo;
        int rhi;
        int clo;
        int chi;
        longint best;
        longint d;
        longint diff;
        som_out_t res;
        if (it.mode == MODE_WEIGHT) begin
            weight_mem[addr(it.neuron_row, it.neuron_col, it.element_index)] = it.element_value;
            return;
        end
        sample_mem[it.element_index] = it.element_value;
        if (!it.last) return;
        rows = clip(rows_reg);
        cols = clip(cols_reg);
        len = clip(len_reg);
        best = -1;
        br = 0;
        bc = 0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                d = 0;
                for (int k = 0; k < len; k++) begin
                    diff = longint'(sample_mem[k]) - longint'(weight_mem[addr(r, c, k)]);
                    d += diff * diff;
                end
                if (best < 0 || d < best) begin
                    best = d;
                    br = r;
                    bc = c;
                end
            end
        end
        rlo = (br >= radius_reg) ? br - radius_reg : 0;
        clo = (bc >= radius_reg) ? bc - radius_reg : 0;
        rhi = (br + radius_reg > rows - 1) ? rows - 1 : br + radius_reg;
        chi = (bc + radius_reg > cols - 1) ? cols - 1 : bc + radius_reg;
        for (int r = rlo; r <= rhi; r++)
            for (int c = clo; c <= chi; c++)
                for (int k = 0; k < len; k++)
                    weight_mem[addr(r, c, k)] = nudge(weight_mem[addr(r, c, k)], sample_mem[k]);
        res.winner_row = br[3:0];
        res.winner_col = bc[3:0];
        res.winner_distance = best[35:0];
        expected_wins.push_back(res);
    endfunction

    // Extremes and zero turn up often so that ties and full-scale differences occur.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void queue_item(input logic m, input int r, input int c, input int k,
                                       input logic [15:0] v, input logic l);
        som_in_t it;
        it.mode = m;
        it.neuron_row = r[3:0];
        it.neuron_col = c[3:0];
        it.element_index = k[3:0];
        it.element_value = v;
        it.last = l;
        if (m == MODE_WEIGHT) weight_loaded[addr(r, c, k)] = 1'b1;
        else sample_loaded[k] = 1'b1;
        if (m == MODE_SAMPLE && l) finals_made++;
        pending_items.push_back(it);
        items_made++;
    endfunction

    // A final sample may only go out once every entry the search reads holds data.
    function automatic bit final_ok(input int own_k);
        for (int k = 0; k < clip(len_reg); k++)
            if (!sample_loaded[k] && k != own_k) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void fill_grid();
        for (int r = 0; r < clip(rows_reg); r++)
            for (int c = 0; c < clip(cols_reg); c++)
                for (int k = 0; k < clip(len_reg); k++)
                    if (!weight_loaded[addr(r, c, k)])
                        queue_item(MODE_WEIGHT, $urandom_range(0, 15) == 0 ? r : r, c, k,
                                   pick_value(), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void random_items(input int count);
        int made;
        int k;
        int len;
        made = 0;
        len = clip(len_reg);
        while (made < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    for (int j = 0; j < len; j++)
                        queue_item(MODE_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 15), j,
                                   pick_value(), j == len - 1);
                    made += len;
                end
                6, 7: begin
                    queue_item(MODE_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), pick_value(), 1'($urandom_range(0, 1)));
                    made++;
                end
                8: begin
                    queue_item(MODE_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), pick_value(), 1'b0);
                    made++;
                end
                default: begin
                    k = $urandom_range(0, 15);
                    queue_item(MODE_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 15), k,
                               pick_value(), final_ok(k));
                    made++;
                end
            endcase
        end
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_ch.valid || expected_wins.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_config(input int rows, input int cols, input int len,
                              input int rate, input int rad);
        logic [CFG_IDX_W-1:0] idx [5];
        int vals [5];
        idx = '{CFG_GRID_ROWS, CFG_GRID_COLS, CFG_VECTOR_LENGTH, CFG_LEARN_RATE, CFG_RADIUS};
        vals = '{rows, cols, len, rate, rad};
        wait_idle();
        for (int i = 0; i < 5; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= 16'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        rows_reg = 5'(rows);
        cols_reg = 5'(cols);
        len_reg = 5'(len);
        rate_reg = 16'(rate);
        radius_reg = 4'(rad);
    endtask

    // Sender: holds each item until accepted, with a random gap after each one.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else begin
            if (in_ch.valid && in_ch.ready) begin
                train_step(in_ch.data);
                items_in++;
                send_gap = ((items_in / 60) % 4 == 3) ? 0 : $urandom_range(0, 11);
            end
            if (in_ch.valid && !in_ch.ready)
                in_ch.valid <= 1'b1;
            else if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0) begin
                in_ch.data <= pending_items.pop_front();
                in_ch.valid <= 1'b1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: checks each win report and stalls at random, once for a long stretch.
    always @(posedge clk) begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else begin
            if (out_ch.valid && out_ch.ready) begin
                wins_out++;
                if (expected_wins.size() == 0) begin
                    $error("unexpected result row=%0d col=%0d dist=%0d",
                           out_ch.data.winner_row, out_ch.data.winner_col,
                           out_ch.data.winner_distance);
                    errors++;
                end
                else begin
                    som_out_t exp_w;
                    exp_w = expected_wins.pop_front();
                    if (out_ch.data.winner_row !== exp_w.winner_row) begin
                        $error("winner_row expected %0d got %0d",
                               exp_w.winner_row, out_ch.data.winner_row);
                        errors++;
                    end
                    if (out_ch.data.winner_col !== exp_w.winner_col) begin
                        $error("winner_col expected %0d got %0d",
                               exp_w.winner_col, out_ch.data.winner_col);
                        errors++;
                    end
                    if (out_ch.data.winner_distance !== exp_w.winner_distance) begin
                        $error("winner_distance expected %0d got %0d",
                               exp_w.winner_distance, out_ch.data.winner_distance);
                        errors++;
                    end
                end
                recv_gap = ((wins_out / 20) % 4 == 1) ? 0 : $urandom_range(0, 11);
            end
            if (!hold_done && items_in >= 500) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial begin
        #200_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int rr;
        int cc;
        int ll;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Full 16x16 grid with one element, widest window and fastest rate.
        set_config(16, 16, 1, 65535, 15);
        fill_grid();
        queue_item(MODE_SAMPLE, 15, 15, 0, 16'h8000, 1'b1);
        queue_item(MODE_SAMPLE, 0, 0, 0, 16'h7FFF, 1'b1);
        queue_item(MODE_WEIGHT, 15, 15, 15, 16'h7FFF, 1'b1);
        queue_item(MODE_SAMPLE, 0, 0, 15, 16'h8000, 1'b0);
        queue_item(MODE_SAMPLE, 0, 0, 15, 16'h1234, 1'b1);
        queue_item(MODE_SAMPLE, 0, 0, 0, 16'h0000, 1'b1);

        // Zero and oversized registers: first no movement and a single-neuron window, then half rate.
        set_config(0, 1, 31, 0, 0);
        fill_grid();
        for (int k = 0; k < 16; k++)
            queue_item(MODE_SAMPLE, 0, 0, k, k[0] ? 16'h7FFF : 16'h8000, k == 15);
        set_config(1, 31, 0, 32768, 15);
        queue_item(MODE_SAMPLE, 0, 0, 0, 16'h7FFF, 1'b1);
        queue_item(MODE_SAMPLE, 0, 0, 3, 16'hC000, 1'b1);

        while (items_made < TARGET_ITEMS) begin
            rr = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 6);
            cc = $urandom_range(0, 6);
            ll = (rr > 16) ? $urandom_range(0, 2) : $urandom_range(0, 4);
            set_config(rr, cc, ll, $urandom_range(0, 65535), $urandom_range(0, 15));
            fill_grid();
            random_items(60);
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (expected_wins.size() != 0) begin
            $error("%0d expected results never arrived", expected_wins.size());
            errors++;
        end
        $display("Covered %0d items (%0d final samples) and %0d win reports", items_in,
                 finals_made, wins_out);
        $display("over full and small grids, clamped registers, and edge rates and radii.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
